// ----- hw/rtl/sdiv_pkg.sv -----
// Shared types and constants for the signed 64-by-32 divider.
package sdiv_pkg;

  localparam int unsigned DIVIDEND_W = 64;
  localparam int unsigned DIVISOR_W  = 32;
  localparam int unsigned QUOTIENT_W = 32;
  localparam int unsigned DIV_STEPS  = 64;

  typedef struct packed {
    logic                  valid;
    logic                  neg;
    logic [DIVIDEND_W-1:0] mag;
    logic [DIVISOR_W-1:0]  part;
    logic [QUOTIENT_W-1:0] q;
    logic [DIVISOR_W-1:0]  d;
  } sdiv_stage_t;

endpackage

// ----- hw/rtl/sdiv_in_if.sv -----
// Input channel carrying the dividend and divisor of one beat.
interface sdiv_in_if
  import sdiv_pkg::*;
  ();
  logic                         valid;
  logic                         ready;
  logic signed [DIVIDEND_W-1:0] dividend;
  logic        [DIVISOR_W-1:0]  divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

// ----- hw/rtl/sdiv_out_if.sv -----
// Result channel carrying the quotient of one beat.
interface sdiv_out_if
  import sdiv_pkg::*;
  ();
  logic                         valid;
  logic                         ready;
  logic signed [QUOTIENT_W-1:0] quotient;

  modport source (output valid, output quotient, input ready);
  modport sink   (input valid, input quotient, output ready);
endinterface

// ----- hw/rtl/sdiv_prep.sv -----
// Input stage that registers the divisor and the dividend's magnitude and sign.
module sdiv_prep
  import sdiv_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [DIVIDEND_W-1:0] in_dividend,
  input  logic        [DIVISOR_W-1:0]  in_divisor,
  output sdiv_stage_t                  stage_r
);

  logic [DIVIDEND_W-1:0] raw;
  sdiv_stage_t           stage_nxt;

  always_comb begin
    raw             = $unsigned(in_dividend);
    stage_nxt.valid = in_valid;
    stage_nxt.neg   = raw[DIVIDEND_W-1];
    stage_nxt.mag   = raw[DIVIDEND_W-1] ? (~raw + {{(DIVIDEND_W-1){1'b0}}, 1'b1}) : raw;
    stage_nxt.part  = '0;
    stage_nxt.q     = '0;
    stage_nxt.d     = in_divisor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r.valid <= stage_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r.neg  <= stage_nxt.neg;
      stage_r.mag  <= stage_nxt.mag;
      stage_r.part <= stage_nxt.part;
      stage_r.q    <= stage_nxt.q;
      stage_r.d    <= stage_nxt.d;
    end
  end

endmodule

// ----- hw/rtl/sdiv_step_stage.sv -----
// One pipeline stage that performs a fixed number of restoring division steps.
module sdiv_step_stage
  import sdiv_pkg::*;
#(
  parameter int unsigned STEPS = 2
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  sdiv_stage_t stage_in,
  output sdiv_stage_t stage_r
);

  sdiv_stage_t stage_nxt;

  always_comb begin
    logic                 top;
    logic [DIVISOR_W-1:0] shifted;
    logic [DIVISOR_W+1:0] diff;
    stage_nxt = stage_in;
    for (int unsigned k = 0; k < STEPS; k++) begin
      top     = stage_nxt.part[DIVISOR_W-1];
      shifted = {stage_nxt.part[DIVISOR_W-2:0], stage_nxt.mag[DIVIDEND_W-1]};
      diff    = {1'b0, top, shifted} - {2'b00, stage_nxt.d};
      stage_nxt.mag = {stage_nxt.mag[DIVIDEND_W-2:0], 1'b0};
      if (!diff[DIVISOR_W+1]) begin
        stage_nxt.part = diff[DIVISOR_W-1:0];
        stage_nxt.q    = {stage_nxt.q[QUOTIENT_W-2:0], 1'b1};
      end else begin
        stage_nxt.part = shifted;
        stage_nxt.q    = {stage_nxt.q[QUOTIENT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r.valid <= stage_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r.neg  <= stage_nxt.neg;
      stage_r.mag  <= stage_nxt.mag;
      stage_r.part <= stage_nxt.part;
      stage_r.q    <= stage_nxt.q;
      stage_r.d    <= stage_nxt.d;
    end
  end

endmodule

// ----- hw/rtl/sdiv_fix.sv -----
// Output stage that restores the quotient's sign and holds the result beat.
module sdiv_fix
  import sdiv_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  sdiv_stage_t                  stage_in,
  output logic                         out_valid_r,
  output logic signed [QUOTIENT_W-1:0] out_quotient_r
);

  logic [QUOTIENT_W-1:0] quotient_nxt;

  always_comb begin
    quotient_nxt = stage_in.neg ? (~stage_in.q + {{(QUOTIENT_W-1){1'b0}}, 1'b1})
                                : stage_in.q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_quotient_r <= $signed(quotient_nxt);
    end
  end

endmodule

// ----- hw/rtl/signed_divide_64_by_32_top.sv -----
// Top level of the pipelined signed 64-by-unsigned-32 restoring divider.
// A beat passes the sdiv_prep register, the step stages and the sdiv_fix register.
// Throughput is one beat per cycle unless the output stalls; each stage's depth is set
// by STEPS_PER_STAGE dependent 33-bit subtract-and-compare steps between its registers.
// The whole pipeline holds while a result waits, so a stall loses and repeats nothing.
// Synchronous reset clears every valid bit; the data registers are not reset.
module signed_divide_64_by_32_top
  import sdiv_pkg::*;
#(
  parameter int unsigned STEPS_PER_STAGE = 2
)(
  input  logic        clk,
  input  logic        rst_n,
  sdiv_in_if.sink     in_bus,
  sdiv_out_if.source  out_bus
);

  localparam int unsigned NUM_STAGES = DIV_STEPS / STEPS_PER_STAGE;

  logic        en;
  logic        out_valid_r;
  logic signed [QUOTIENT_W-1:0] out_quotient_r;
  sdiv_stage_t stage_s [0:NUM_STAGES];

  assign en            = !out_valid_r || out_bus.ready;
  assign in_bus.ready  = en;
  assign out_bus.valid = out_valid_r;
  assign out_bus.quotient = out_quotient_r;

  sdiv_prep u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_bus.valid),
    .in_dividend (in_bus.dividend),
    .in_divisor  (in_bus.divisor),
    .stage_r     (stage_s[0])
  );

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_step
    sdiv_step_stage #(
      .STEPS (STEPS_PER_STAGE)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .stage_in (stage_s[i]),
      .stage_r  (stage_s[i+1])
    );
  end

  sdiv_fix u_fix (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .stage_in       (stage_s[NUM_STAGES]),
    .out_valid_r    (out_valid_r),
    .out_quotient_r (out_quotient_r)
  );

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> stage_s[0].valid)
    else $error("accepted input beat did not enter the pipeline");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (en && stage_s[NUM_STAGES].valid) |=> out_valid_r)
    else $error("finished beat did not reach the output register");

  a_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (en && stage_s[NUM_STAGES].valid && (stage_s[NUM_STAGES].d == '0)
     && !stage_s[NUM_STAGES].neg) |=> (out_quotient_r == '1))
    else $error("zero divisor with positive dividend did not give all ones");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(stage_s[NUM_STAGES].valid) && $stable(stage_s[NUM_STAGES].q))
    else $error("pipeline moved while the output was stalled");

endmodule
